// ===== src/prnh_pkg.sv =====
// Shared types and constants for the polyline ray nearest-hit block.
// No dependencies; imported by every module of the block but prnh_ram.
package prnh_pkg;

   localparam int IDX_W    = 12;
   localparam int COUNT_W  = 13;
   localparam int RADIUS_W = 12;
   localparam int DIST_W   = 26;
   localparam int COORD_W  = 32;
   localparam int DIR_W    = 16;
   localparam int QUOT_W   = 27;

   localparam logic CMD_WRITE = 1'b0;
   localparam logic CMD_CAST  = 1'b1;

   localparam logic [1:0] REG_POINT_COUNT   = 2'd0;
   localparam logic [1:0] REG_SEARCH_RADIUS = 2'd1;
   localparam logic [1:0] REG_MAX_RANGE     = 2'd2;

   localparam logic [COUNT_W-1:0]  POINT_COUNT_RESET   = 13'd0;
   localparam logic [RADIUS_W-1:0] SEARCH_RADIUS_RESET = 12'd64;
   localparam logic [DIST_W-1:0]   MAX_RANGE_RESET     = 26'd3276800;

   typedef struct packed {
      logic                       is_cast;
      logic [IDX_W-1:0]           point_index;
      logic signed [COORD_W-1:0]  point_x;
      logic signed [COORD_W-1:0]  point_y;
      logic signed [COORD_W-1:0]  origin_x;
      logic signed [COORD_W-1:0]  origin_y;
      logic signed [DIR_W-1:0]    dir_x;
      logic signed [DIR_W-1:0]    dir_y;
   } item_type;

   typedef struct packed {
      logic [DIST_W-1:0] distance;
      logic              hit;
      logic [IDX_W-1:0]  located_segment;
   } result_type;

endpackage

// ===== src/prnh_ram.sv =====
// Generic single-write, dual-read RAM with registered read data.
// No dependencies.
module prnh_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr_a,
   output logic [WIDTH-1:0]         rdata_a,
   input  logic [$clog2(DEPTH)-1:0] raddr_b,
   output logic [WIDTH-1:0]         rdata_b
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_a <= mem[raddr_a];
      rdata_b <= mem[raddr_b];
   end
endmodule

// ===== src/prnh_front.sv =====
// Front end: accepts request items, tags writes and casts, and queues them.
// Depends on prnh_pkg.
module prnh_front (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_push,
   output logic                      req_full,
   input  logic                      req_cmd,
   input  logic [11:0]               req_point_index,
   input  logic signed [31:0]        req_point_x,
   input  logic signed [31:0]        req_point_y,
   input  logic signed [31:0]        req_origin_x,
   input  logic signed [31:0]        req_origin_y,
   input  logic signed [15:0]        req_dir_x,
   input  logic signed [15:0]        req_dir_y,
   output logic                      q_valid,
   output prnh_pkg::item_type        q_item,
   input  logic                      q_pop
);
   import prnh_pkg::*;

   item_type   entry_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   item_type   item;
   logic       push_ok, pop_ok;

   always_comb begin
      item.is_cast     = (req_cmd == CMD_CAST);
      item.point_index = req_point_index;
      item.point_x     = req_point_x;
      item.point_y     = req_point_y;
      item.origin_x    = req_origin_x;
      item.origin_y    = req_origin_y;
      item.dir_x       = req_dir_x;
      item.dir_y       = req_dir_y;
   end

   assign req_full = (count_ff == 2'd2);
   assign q_valid  = (count_ff != 2'd0);
   assign q_item   = entry_ff[rd_ptr_ff];
   assign push_ok  = req_push && !req_full;
   assign pop_ok   = q_pop && q_valid;

   always_comb begin
      wr_ptr_in = push_ok ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop_ok ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(push_ok) - 2'(pop_ok);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_ok) begin
         entry_ff[wr_ptr_ff] <= item;
      end
   end
endmodule

// ===== src/prnh_back.sv =====
// Back end: point table, binary search, segment scan with a shared multiplier
// and a bit-serial divider, and the result register. Depends on prnh_pkg, prnh_ram.
module prnh_back #(
   parameter int MAX_POINTS    = 4096,
   parameter int DIR_FRAC_BITS = 14
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              q_valid,
   input  prnh_pkg::item_type                q_item,
   output logic                              q_pop,
   input  logic [prnh_pkg::COUNT_W-1:0]      point_count,
   input  logic [prnh_pkg::RADIUS_W-1:0]     search_radius,
   input  logic [prnh_pkg::DIST_W-1:0]       max_range,
   output logic                              rsp_empty,
   input  logic                              rsp_pop,
   output prnh_pkg::result_type              rsp_result
);
   import prnh_pkg::*;

   localparam int AW = $clog2(MAX_POINTS);
   localparam int CW = AW + 1;
   localparam int PW = (CW > COUNT_W) ? CW : COUNT_W;
   localparam int SW = ((AW > IDX_W) ? AW : IDX_W) + 3;
   localparam int NW = 69 + DIR_FRAC_BITS;
   localparam int DW = ((NW > 77) ? NW : 77) + 1;

   localparam logic [3:0] ST_IDLE      = 4'd0;
   localparam logic [3:0] ST_BS_RD     = 4'd1;
   localparam logic [3:0] ST_BS_CMP    = 4'd2;
   localparam logic [3:0] ST_SCAN_INIT = 4'd3;
   localparam logic [3:0] ST_SEG_RD    = 4'd4;
   localparam logic [3:0] ST_SEG_LD    = 4'd5;
   localparam logic [3:0] ST_MUL       = 4'd6;
   localparam logic [3:0] ST_TEST      = 4'd7;
   localparam logic [3:0] ST_DIV       = 4'd8;
   localparam logic [3:0] ST_ACC       = 4'd9;
   localparam logic [3:0] ST_DONE      = 4'd10;

   logic [3:0]              state_ff, state_in;
   logic signed [SW-1:0]    lo_ff, lo_in, hi_ff, hi_in, mid_ff, mid_in;
   logic signed [SW-1:0]    cur_ff, cur_in, idx_ff, idx_in, end_ff, end_in;
   logic signed [31:0]      ox_ff, ox_in, oy_ff, oy_in;
   logic signed [15:0]      dx_ff, dx_in, dy_ff, dy_in;
   logic signed [33:0]      ex_ff, ex_in, ey_ff, ey_in, wx_ff, wx_in, wy_ff, wy_in;
   logic signed [67:0]      mul_ff, mul_in;
   logic signed [68:0]      acc_ff, acc_in, nt_ff, nt_in;
   logic signed [50:0]      den_ff, den_in, ns_ff, ns_in;
   logic [2:0]              cnt_ff, cnt_in;
   logic [DW-1:0]           rem_ff, rem_in, dsh_ff, dsh_in;
   logic [QUOT_W-1:0]       quo_ff, quo_in;
   logic [4:0]              bcnt_ff, bcnt_in;
   logic [DIST_W-1:0]       nearest_ff, nearest_in;
   logic                    hit_ff, hit_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   result_type              rsp_ff, rsp_in;

   logic [PW-1:0]           pc_ext, vc_ext;
   logic signed [SW-1:0]    vc_s, radius_s, mid_calc, beg_calc, end_calc, segs_s;
   logic                    ram_we;
   logic [AW-1:0]           ram_waddr, raddr_a, raddr_b;
   logic [63:0]             rdata_a, rdata_b;
   logic signed [32:0]      ax, ay, bx, by;
   logic signed [33:0]      ma, mb;
   logic signed [68:0]      nt_mag_s;
   logic [68:0]             nt_mag;
   logic [50:0]             dm;
   logic [DW-1:0]           num, dm_big;
   logic                    rem_ge, load_rsp, seg_fail;

   // Clamp the point count to the table size.
   assign pc_ext   = PW'(point_count);
   assign vc_ext   = (pc_ext > PW'(MAX_POINTS)) ? PW'(MAX_POINTS) : pc_ext;
   assign vc_s     = signed'(SW'(vc_ext));
   assign radius_s = signed'(SW'(search_radius));
   assign segs_s   = vc_s - SW'(1);
   assign mid_calc = lo_ff + ((hi_ff - lo_ff + SW'(1)) >>> 1);
   assign beg_calc = cur_ff - radius_s;
   assign end_calc = cur_ff + radius_s + SW'(1);

   assign ax = {rdata_a[31:0], 1'b0};
   assign ay = {rdata_a[63:32], 1'b0};
   assign bx = {rdata_b[31:0], 1'b0};
   assign by = {rdata_b[63:32], 1'b0};

   assign ram_we    = (state_ff == ST_IDLE) && q_valid && !q_item.is_cast &&
                      (32'(q_item.point_index) < 32'(MAX_POINTS));
   assign ram_waddr = AW'(q_item.point_index);
   assign raddr_a   = (state_ff == ST_BS_RD) ? mid_calc[AW-1:0] : idx_ff[AW-1:0];
   assign raddr_b   = AW'(idx_ff + SW'(1));

   prnh_ram #(.WIDTH(64), .DEPTH(MAX_POINTS)) u_points (
      .clock   (clock),
      .we      (ram_we),
      .waddr   (ram_waddr),
      .wdata   ({q_item.point_y, q_item.point_x}),
      .raddr_a (raddr_a),
      .rdata_a (rdata_a),
      .raddr_b (raddr_b),
      .rdata_b (rdata_b)
   );

   // Operand select for the shared multiplier.
   always_comb begin
      case (cnt_ff)
         3'd0:    begin ma = 34'(dx_ff); mb = ey_ff; end
         3'd1:    begin ma = 34'(dy_ff); mb = ex_ff; end
         3'd2:    begin ma = wx_ff; mb = 34'(dy_ff); end
         3'd3:    begin ma = wy_ff; mb = 34'(dx_ff); end
         3'd4:    begin ma = wx_ff; mb = ey_ff; end
         default: begin ma = wy_ff; mb = ex_ff; end
      endcase
   end

   assign nt_mag_s = nt_ff[68] ? -nt_ff : nt_ff;
   assign nt_mag   = nt_mag_s;
   assign dm       = den_ff[50] ? 51'(-den_ff) : 51'(den_ff);
   assign num      = DW'(nt_mag) << DIR_FRAC_BITS;
   assign dm_big   = DW'(dm) << QUOT_W;
   assign rem_ge   = (rem_ff >= dsh_ff);
   assign load_rsp = (state_ff == ST_DONE) && (!rsp_valid_ff || rsp_pop);

   // Parallel segments, s outside [0,1], negative t, or t past the limit.
   always_comb begin
      seg_fail = 1'b0;
      if (den_ff == '0) begin
         seg_fail = 1'b1;
      end else if (!den_ff[50]) begin
         if (ns_ff[50] || ns_ff > den_ff) seg_fail = 1'b1;
      end else begin
         if ((!ns_ff[50] && ns_ff != '0) || ns_ff < den_ff) seg_fail = 1'b1;
      end
      if (nt_ff != '0 && nt_ff[68] != den_ff[50]) seg_fail = 1'b1;
      if (num >= dm_big) seg_fail = 1'b1;
   end

   always_comb begin
      state_in     = state_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      mid_in       = mid_ff;
      cur_in       = cur_ff;
      idx_in       = idx_ff;
      end_in       = end_ff;
      ox_in        = ox_ff;
      oy_in        = oy_ff;
      dx_in        = dx_ff;
      dy_in        = dy_ff;
      ex_in        = ex_ff;
      ey_in        = ey_ff;
      wx_in        = wx_ff;
      wy_in        = wy_ff;
      mul_in       = mul_ff;
      acc_in       = acc_ff;
      den_in       = den_ff;
      ns_in        = ns_ff;
      nt_in        = nt_ff;
      cnt_in       = cnt_ff;
      rem_in       = rem_ff;
      dsh_in       = dsh_ff;
      quo_in       = quo_ff;
      bcnt_in      = bcnt_ff;
      nearest_in   = nearest_ff;
      hit_in       = hit_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_pop;
      q_pop        = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (q_valid) begin
               q_pop = 1'b1;
               if (q_item.is_cast) begin
                  ox_in      = q_item.origin_x;
                  oy_in      = q_item.origin_y;
                  dx_in      = q_item.dir_x;
                  dy_in      = q_item.dir_y;
                  nearest_in = max_range;
                  hit_in     = 1'b0;
                  lo_in      = '0;
                  hi_in      = vc_s - SW'(2);
                  if (hi_in[SW-1] || hi_in == '0) begin
                     cur_in   = '0;
                     state_in = ST_SCAN_INIT;
                  end else begin
                     state_in = ST_BS_RD;
                  end
               end
            end
         end
         ST_BS_RD: begin
            if (lo_ff < hi_ff) begin
               mid_in   = mid_calc;
               state_in = ST_BS_CMP;
            end else begin
               cur_in   = lo_ff;
               state_in = ST_SCAN_INIT;
            end
         end
         ST_BS_CMP: begin
            if (ax <= 33'(ox_ff)) lo_in = mid_ff;
            else hi_in = mid_ff - SW'(1);
            state_in = ST_BS_RD;
         end
         ST_SCAN_INIT: begin
            idx_in   = beg_calc[SW-1] ? '0 : beg_calc;
            end_in   = (end_calc > segs_s) ? segs_s : end_calc;
            state_in = ST_SEG_RD;
         end
         ST_SEG_RD: begin
            state_in = (idx_ff >= end_ff) ? ST_DONE : ST_SEG_LD;
         end
         ST_SEG_LD: begin
            ex_in    = 34'(bx) - 34'(ax);
            ey_in    = 34'(by) - 34'(ay);
            wx_in    = 34'(ax) - 34'(ox_ff);
            wy_in    = 34'(ay) - 34'(oy_ff);
            cnt_in   = '0;
            state_in = ST_MUL;
         end
         ST_MUL: begin
            // Register one product a cycle; fold in the previous one.
            if (cnt_ff != 3'd6) mul_in = ma * mb;
            case (cnt_ff)
               3'd1:    acc_in = 69'(mul_ff);
               3'd2:    den_in = 51'(acc_ff - 69'(mul_ff));
               3'd3:    acc_in = 69'(mul_ff);
               3'd4:    ns_in  = 51'(acc_ff - 69'(mul_ff));
               3'd5:    acc_in = 69'(mul_ff);
               3'd6:    nt_in  = acc_ff - 69'(mul_ff);
               default: acc_in = acc_ff;
            endcase
            cnt_in = cnt_ff + 3'd1;
            if (cnt_ff == 3'd6) state_in = ST_TEST;
         end
         ST_TEST: begin
            if (seg_fail) begin
               idx_in   = idx_ff + SW'(1);
               state_in = ST_SEG_RD;
            end else begin
               rem_in   = num;
               dsh_in   = DW'(dm) << (QUOT_W - 1);
               quo_in   = '0;
               bcnt_in  = 5'(QUOT_W - 1);
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            rem_in  = rem_ge ? rem_ff - dsh_ff : rem_ff;
            quo_in  = {quo_ff[QUOT_W-2:0], rem_ge};
            dsh_in  = dsh_ff >> 1;
            bcnt_in = bcnt_ff - 5'd1;
            if (bcnt_ff == '0) state_in = ST_ACC;
         end
         ST_ACC: begin
            if (quo_ff <= QUOT_W'(nearest_ff)) begin
               nearest_in = DIST_W'(quo_ff);
               hit_in     = 1'b1;
            end
            idx_in   = idx_ff + SW'(1);
            state_in = ST_SEG_RD;
         end
         ST_DONE: begin
            if (load_rsp) begin
               rsp_in.distance        = nearest_ff;
               rsp_in.hit             = hit_ff;
               rsp_in.located_segment = cur_ff[IDX_W-1:0];
               rsp_valid_in           = 1'b1;
               state_in               = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      lo_ff      <= lo_in;
      hi_ff      <= hi_in;
      mid_ff     <= mid_in;
      cur_ff     <= cur_in;
      idx_ff     <= idx_in;
      end_ff     <= end_in;
      ox_ff      <= ox_in;
      oy_ff      <= oy_in;
      dx_ff      <= dx_in;
      dy_ff      <= dy_in;
      ex_ff      <= ex_in;
      ey_ff      <= ey_in;
      wx_ff      <= wx_in;
      wy_ff      <= wy_in;
      mul_ff     <= mul_in;
      acc_ff     <= acc_in;
      den_ff     <= den_in;
      ns_ff      <= ns_in;
      nt_ff      <= nt_in;
      cnt_ff     <= cnt_in;
      rem_ff     <= rem_in;
      dsh_ff     <= dsh_in;
      quo_ff     <= quo_in;
      bcnt_ff    <= bcnt_in;
      nearest_ff <= nearest_in;
      hit_ff     <= hit_in;
      rsp_ff     <= rsp_in;
   end

   assign rsp_empty  = !rsp_valid_ff;
   assign rsp_result = rsp_ff;

`ifndef SYNTHESIS
   a_load_shows: assert property (@(posedge clock) disable iff (reset)
      load_rsp |=> rsp_valid_ff)
      else $error("loaded result not shown");
   a_scan_end: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SEG_RD && idx_ff >= end_ff) |=> state_ff == ST_DONE)
      else $error("scan ran past its end");
   a_pop_only_idle: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> (state_ff == ST_IDLE && q_valid))
      else $error("queue popped while busy");
`endif
endmodule

// ===== src/polyline_ray_nearest_hit.sv =====
// Top level: configuration registers, request front end and execution back end.
// Depends on prnh_pkg, prnh_front, prnh_back (which holds prnh_ram).
// A request waits in the front-end queue until the back end pops it in idle.
// A cast then runs the binary search when there are three or more points,
// scans its segments and sends each one that passes the test to the divider.
// A write is stored as it is popped; a cast holds the back end until its result
// loads, so casts run one at a time (up to 129 segments at the default radius).
// Reset is synchronous; it empties both queues and loads register defaults.
module polyline_ray_nearest_hit #(
   parameter int MAX_POINTS    = 4096,
   parameter int DIR_FRAC_BITS = 14
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_push,
   output logic               req_full,
   input  logic               req_cmd,
   input  logic [11:0]        req_point_index,
   input  logic signed [31:0] req_point_x,
   input  logic signed [31:0] req_point_y,
   input  logic signed [31:0] req_origin_x,
   input  logic signed [31:0] req_origin_y,
   input  logic signed [15:0] req_dir_x,
   input  logic signed [15:0] req_dir_y,
   output logic               rsp_empty,
   input  logic               rsp_pop,
   output logic [25:0]        rsp_distance,
   output logic               rsp_hit,
   output logic [11:0]        rsp_located_segment,
   input  logic               csr_psel,
   input  logic               csr_penable,
   input  logic               csr_pwrite,
   input  logic [3:0]         csr_paddr,
   input  logic [31:0]        csr_pwdata,
   output logic [31:0]        csr_prdata,
   output logic               csr_pready
);
   import prnh_pkg::*;

   logic [COUNT_W-1:0]  point_count_ff, point_count_in;
   logic [RADIUS_W-1:0] search_radius_ff, search_radius_in;
   logic [DIST_W-1:0]   max_range_ff, max_range_in;
   logic                csr_wr;
   logic [1:0]          csr_reg;
   logic                q_valid, q_pop;
   item_type            q_item;
   result_type          rsp_result;

   // Register file: a write lands on the access phase, decoded by word address.
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_reg    = csr_paddr[3:2];

   always_comb begin
      point_count_in   = point_count_ff;
      search_radius_in = search_radius_ff;
      max_range_in     = max_range_ff;
      if (csr_wr) begin
         case (csr_reg)
            REG_POINT_COUNT:   point_count_in   = csr_pwdata[COUNT_W-1:0];
            REG_SEARCH_RADIUS: search_radius_in = csr_pwdata[RADIUS_W-1:0];
            REG_MAX_RANGE:     max_range_in     = csr_pwdata[DIST_W-1:0];
            default:           point_count_in   = point_count_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         point_count_ff   <= POINT_COUNT_RESET;
         search_radius_ff <= SEARCH_RADIUS_RESET;
         max_range_ff     <= MAX_RANGE_RESET;
      end else begin
         point_count_ff   <= point_count_in;
         search_radius_ff <= search_radius_in;
         max_range_ff     <= max_range_in;
      end
   end

   // Read back the addressed register; unused addresses read zero.
   always_comb begin
      case (csr_reg)
         REG_POINT_COUNT:   csr_prdata = 32'(point_count_ff);
         REG_SEARCH_RADIUS: csr_prdata = 32'(search_radius_ff);
         REG_MAX_RANGE:     csr_prdata = 32'(max_range_ff);
         default:           csr_prdata = '0;
      endcase
   end

   // Front end: hold up to two requests so the back end can stall on its own.
   prnh_front u_front (
      .clock           (clock),
      .reset           (reset),
      .req_push        (req_push),
      .req_full        (req_full),
      .req_cmd         (req_cmd),
      .req_point_index (req_point_index),
      .req_point_x     (req_point_x),
      .req_point_y     (req_point_y),
      .req_origin_x    (req_origin_x),
      .req_origin_y    (req_origin_y),
      .req_dir_x       (req_dir_x),
      .req_dir_y       (req_dir_y),
      .q_valid         (q_valid),
      .q_item          (q_item),
      .q_pop           (q_pop)
   );

   // Back end: store points, search, scan segments, and hold one result.
   prnh_back #(
      .MAX_POINTS    (MAX_POINTS),
      .DIR_FRAC_BITS (DIR_FRAC_BITS)
   ) u_back (
      .clock         (clock),
      .reset         (reset),
      .q_valid       (q_valid),
      .q_item        (q_item),
      .q_pop         (q_pop),
      .point_count   (point_count_ff),
      .search_radius (search_radius_ff),
      .max_range     (max_range_ff),
      .rsp_empty     (rsp_empty),
      .rsp_pop       (rsp_pop),
      .rsp_result    (rsp_result)
   );

   assign rsp_distance        = rsp_result.distance;
   assign rsp_hit             = rsp_result.hit;
   assign rsp_located_segment = rsp_result.located_segment;
endmodule

// ===== tb/tb_polyline_ray_nearest_hit.sv =====
// Self-checking testbench for polyline_ray_nearest_hit: queue-style request and
// response channels, an APB-style register port and a bit-exact hit predictor.
// Depends on prnh_pkg and the polyline_ray_nearest_hit RTL.
module tb_polyline_ray_nearest_hit;
   timeunit 1ns;
   timeprecision 1ps;

   import prnh_pkg::*;

   localparam int TABLE_DEPTH = 4096;
   localparam int TRACK_FILL  = 136;        // low table entries written up front
   localparam int FRAC_BITS   = 14;
   localparam int DRAIN_WAIT  = 400;        // covers queued writes still in the block
   localparam int HOLD_CYCLES = 5000;       // long receiver hold-off
   localparam longint CYCLE_LIMIT = 8000000;

   logic               clock;
   logic               reset;
   logic               req_push;
   logic               req_full;
   logic               req_cmd;
   logic [11:0]        req_point_index;
   logic signed [31:0] req_point_x;
   logic signed [31:0] req_point_y;
   logic signed [31:0] req_origin_x;
   logic signed [31:0] req_origin_y;
   logic signed [15:0] req_dir_x;
   logic signed [15:0] req_dir_y;
   logic               rsp_empty;
   logic               rsp_pop;
   logic [25:0]        rsp_distance;
   logic               rsp_hit;
   logic [11:0]        rsp_located_segment;
   logic               csr_psel;
   logic               csr_penable;
   logic               csr_pwrite;
   logic [3:0]         csr_paddr;
   logic [31:0]        csr_pwdata;
   logic [31:0]        csr_prdata;
   logic               csr_pready;

   polyline_ray_nearest_hit uut (.*);

   // Requests waiting to be offered, and cast results still owed by the block.
   item_type   pending_requests[$];
   result_type owed_results[$];

   // Shadow of the point table and of the registers.
   logic [63:0]         track_shadow [TABLE_DEPTH];
   logic [COUNT_W-1:0]  shadow_count;
   logic [RADIUS_W-1:0] shadow_radius;
   logic [DIST_W-1:0]   shadow_range;

   int     send_idle_pct;
   int     recv_idle_pct;
   int     hold_req;
   int     hold_seen;
   int     hold_left;
   int     errors;
   int     casts_checked;
   int     hits_seen;
   int     random_items;
   longint cycles;
   item_type offered;
   bit     taken;

   // Clock: 10 ns period.
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Point coordinates are doubled whenever the track is read.
   function automatic longint track_x(longint i);
      return 2 * longint'($signed(track_shadow[i][31:0]));
   endfunction

   function automatic longint track_y(longint i);
      return 2 * longint'($signed(track_shadow[i][63:32]));
   endfunction

   // Apply one request to the shadow state; for a cast, compute the owed result.
   function automatic void model_request(item_type it);
      longint valid, lo, hi, mid, seg_lo, seg_hi, cur, i;
      longint ox, oy, dx, dy, sx, sy, ex, ey, wx, wy, den, ns, dm;
      logic signed [127:0] nt, wxw, wyw, exw, eyw;
      logic [127:0] num, lim, q;
      longint nearest;
      bit nneg, got_hit;
      result_type r;
      if (it.is_cast == CMD_WRITE) begin
         track_shadow[it.point_index] = {it.point_y, it.point_x};
         return;
      end
      valid = (shadow_count > TABLE_DEPTH) ? TABLE_DEPTH : shadow_count;
      ox = it.origin_x;
      oy = it.origin_y;
      dx = it.dir_x;
      dy = it.dir_y;
      // Binary search: last segment whose start x is at or below the origin.
      lo = 0;
      hi = valid - 2;
      if (hi > lo) begin
         while (lo < hi) begin
            mid = lo + (hi - lo + 1) / 2;
            if (track_x(mid) <= ox) lo = mid;
            else hi = mid - 1;
         end
      end else begin
         lo = 0;
      end
      cur = lo;
      seg_lo = cur - longint'(shadow_radius);
      seg_hi = cur + longint'(shadow_radius) + 1;
      if (seg_lo < 0) seg_lo = 0;
      if (seg_hi > valid - 1) seg_hi = valid - 1;
      nearest = shadow_range;
      got_hit = 1'b0;
      for (i = seg_lo; i < seg_hi; i++) begin
         sx = track_x(i);
         sy = track_y(i);
         ex = track_x(i + 1) - sx;
         ey = track_y(i + 1) - sy;
         wx = sx - ox;
         wy = sy - oy;
         den = dx * ey - dy * ex;
         if (den == 0) continue;        // parallel: skip
         ns = wx * dy - wy * dx;
         if (den > 0) begin
            if (ns < 0 || ns > den) continue;
         end else begin
            if (ns > 0 || ns < den) continue;
         end
         wxw = wx;
         wyw = wy;
         exw = ex;
         eyw = ey;
         nt = wxw * eyw - wyw * exw;
         nneg = nt[127];
         if (nt != 0 && nneg != (den < 0)) continue;   // behind the origin
         num = nneg ? -nt : nt;
         num = num << FRAC_BITS;
         dm = (den < 0) ? -den : den;
         lim = 128'(nearest + 1) * 128'(dm);
         if (num >= lim) continue;
         q = num / 128'(dm);
         nearest = longint'(q);
         got_hit = 1'b1;
      end
      r.distance = nearest[DIST_W-1:0];
      r.hit = got_hit;
      r.located_segment = cur[IDX_W-1:0];
      owed_results.push_back(r);
   endfunction

   // Sender: offer the next pending request, hold it until accepted.
   always @(posedge clock) begin
      if (reset) begin
         req_push <= 1'b0;
      end else begin
         taken = req_push && !req_full;
         if (taken) model_request(offered);
         if (!req_push || taken) begin
            if (pending_requests.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
               offered = pending_requests.pop_front();
               req_cmd         <= offered.is_cast;
               req_point_index <= offered.point_index;
               req_point_x     <= offered.point_x;
               req_point_y     <= offered.point_y;
               req_origin_x    <= offered.origin_x;
               req_origin_y    <= offered.origin_y;
               req_dir_x       <= offered.dir_x;
               req_dir_y       <= offered.dir_y;
               req_push        <= 1'b1;
            end else begin
               req_push <= 1'b0;
            end
         end
      end
   end

   // Receiver: check each popped result against the oldest owed one.
   always @(posedge clock) begin
      result_type want;
      if (reset) begin
         rsp_pop   <= 1'b0;
         hold_seen <= 0;
         hold_left <= 0;
      end else begin
         if (rsp_pop && !rsp_empty) begin
            if (owed_results.size() == 0) begin
               $error("unexpected result: distance %0d hit %0d segment %0d",
                      rsp_distance, rsp_hit, rsp_located_segment);
               errors++;
            end else begin
               want = owed_results.pop_front();
               casts_checked++;
               if (rsp_hit) hits_seen++;
               if (rsp_distance !== want.distance) begin
                  $error("distance: expected %0d, got %0d", want.distance, rsp_distance);
                  errors++;
               end
               if (rsp_hit !== want.hit) begin
                  $error("hit: expected %0d, got %0d", want.hit, rsp_hit);
                  errors++;
               end
               if (rsp_located_segment !== want.located_segment) begin
                  $error("located_segment: expected %0d, got %0d",
                         want.located_segment, rsp_located_segment);
                  errors++;
               end
            end
         end
         // A new hold request starts a long stall; otherwise pop at random.
         if (hold_req != hold_seen) begin
            hold_seen <= hold_req;
            hold_left <= HOLD_CYCLES;
            rsp_pop   <= 1'b0;
         end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            rsp_pop   <= 1'b0;
         end else begin
            rsp_pop <= ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   // Watchdog.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("FAIL polyline_ray_nearest_hit");
         $finish;
      end
   end

   // Register write: setup cycle, then access cycle; the write lands on the
   // edge where psel, penable and pwrite are all high.
   task automatic reg_write(logic [1:0] which, logic [31:0] value);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {which, 2'b00};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      case (which)
         REG_POINT_COUNT:   shadow_count  = value[COUNT_W-1:0];
         REG_SEARCH_RADIUS: shadow_radius = value[RADIUS_W-1:0];
         default:           shadow_range  = value[DIST_W-1:0];
      endcase
   endtask

   task automatic set_regs(int count, int radius, int range);
      reg_write(REG_POINT_COUNT, count);
      reg_write(REG_SEARCH_RADIUS, radius);
      reg_write(REG_MAX_RANGE, range);
   endtask

   task automatic add_point(int idx, int x, int y);
      item_type it;
      it = '0;
      it.is_cast     = CMD_WRITE;
      it.point_index = IDX_W'(idx);
      it.point_x     = x;
      it.point_y     = y;
      it.origin_x    = $urandom;
      it.origin_y    = $urandom;
      pending_requests.push_back(it);
   endtask

   task automatic add_cast(int ox, int oy, int dx, int dy);
      item_type it;
      it = '0;
      it.is_cast     = CMD_CAST;
      it.point_index = IDX_W'($urandom);
      it.point_x     = $urandom;
      it.point_y     = $urandom;
      it.origin_x    = ox;
      it.origin_y    = oy;
      it.dir_x       = DIR_W'(dx);
      it.dir_y       = DIR_W'(dy);
      pending_requests.push_back(it);
   endtask

   // Wait until every request is in and every owed result is out, then let
   // trailing writes finish before anything touches the registers. Sample on
   // the falling edge so the sender's updates have settled.
   task automatic drain;
      while (pending_requests.size() > 0 || req_push || owed_results.size() > 0)
         @(negedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
   endtask

   function automatic int rand_dir();
      return int'($urandom_range(32768)) - 16384;
   endfunction

   // One random phase: registers, a zigzag track with rising x, then casts
   // from near the track mixed with some noise.
   task automatic random_phase(bit pressure);
      int n, rad, rng, build, base, step, amp, k, casts, sel;
      sel = $urandom_range(9);
      if (sel < 7) n = $urandom_range(3, 40);
      else if (sel == 7) n = $urandom_range(0, 2);
      else if (sel == 8) n = $urandom_range(41, TRACK_FILL);
      else n = $urandom_range(4097, 8191);
      sel = $urandom_range(9);
      if (sel < 6) rad = $urandom_range(0, 8);
      else if (sel == 6) rad = 0;
      else if (sel == 7) rad = 64;
      else if (sel == 8) rad = (n <= 300) ? 4095 : 3;
      else rad = (n <= 300) ? $urandom_range(9, 200) : 2;
      sel = $urandom_range(7);
      if (sel == 0) rng = 1;
      else if (sel == 1) rng = 26'h3FFFFFF;
      else if (sel == 2) rng = MAX_RANGE_RESET;
      else rng = $urandom_range(1000, 26'h3FFFFFF);
      if (pressure) begin
         n = 4;
         rad = 0;
      end
      set_regs(n, rad, rng);
      build = (n > 40) ? 40 : n;
      base = int'($urandom_range(1 << 22)) - (1 << 21);
      step = $urandom_range(1, 4096);
      amp = $urandom_range(1, 1 << 16);
      for (k = 0; k < build; k++) begin
         add_point(k, base + k * step,
                   ((k % 2) ? amp : -amp) + int'($urandom_range(256)) - 128);
         random_items++;
      end
      if (pressure) begin
         casts = 80;
         hold_req++;
      end else begin
         casts = (rad > 64) ? 4 : $urandom_range(12, 24);
      end
      for (k = 0; k < casts; k++) begin
         sel = $urandom_range(9);
         if (sel == 0) begin
            add_cast($urandom, $urandom, rand_dir(), rand_dir());
         end else if (sel == 1 && build > 0) begin
            add_point($urandom_range(build - 1), $urandom, $urandom);
         end else if (sel == 2) begin
            add_cast(2 * (base + int'($urandom_range(build * step + 1))),
                     int'($urandom_range(1 << 17)) - (1 << 16),
                     ($urandom_range(1) ? 16384 : -16384), 0);
         end else begin
            add_cast(2 * (base + int'($urandom_range(build * step + 1)))
                     + int'($urandom_range(3)) - 1,
                     int'($urandom_range(1 << 17)) - (1 << 16),
                     rand_dir(), rand_dir());
         end
         random_items++;
      end
      drain();
   endtask

   initial begin
      int k;
      reset = 1'b1;
      req_cmd = 1'b0;
      req_point_index = '0;
      req_point_x = '0;
      req_point_y = '0;
      req_origin_x = '0;
      req_origin_y = '0;
      req_dir_x = '0;
      req_dir_y = '0;
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = '0;
      csr_pwdata = '0;
      hold_req = 0;
      errors = 0;
      casts_checked = 0;
      hits_seen = 0;
      random_items = 0;
      cycles = 0;
      send_idle_pct = 18;
      recv_idle_pct = 62;
      shadow_count = POINT_COUNT_RESET;
      shadow_radius = SEARCH_RADIUS_RESET;
      shadow_range = MAX_RANGE_RESET;
      for (k = 0; k < TABLE_DEPTH; k++) track_shadow[k] = '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Empty track right after reset: nothing scanned, default range back.
      add_cast(0, 0, 16384, 0);
      drain();

      // Fill the low part of the table. Points far to the right on the first
      // search steps of a full-size count (entries 2047, 1023, 511, 255, 127)
      // steer any oversized count's search and scan into written entries.
      for (k = 0; k < TRACK_FILL; k++)
         add_point(k, int'($urandom_range(1 << 20)) - (1 << 19),
                   int'($urandom_range(1 << 20)) - (1 << 19));
      for (k = 127; k < TABLE_DEPTH; k = 2 * k + 1)
         add_point(k, 32'sh40000000, 0);
      // Small hand-made track: one horizontal segment, then a zigzag.
      add_point(0, 0, 100);
      add_point(1, 100, 100);
      add_point(2, 200, -100);
      add_point(3, 300, 100);
      add_point(4, 400, -100);
      add_point(5, 500, 100);
      add_point(TRACK_FILL - 2, 32'sh7FFFFFFF, 32'sh80000000);
      add_point(TRACK_FILL - 1, 32'sh80000000, 32'sh7FFFFFFF);
      drain();

      // One-point and two-point tracks.
      reg_write(REG_POINT_COUNT, 1);
      add_cast(300, 0, 0, 16384);
      drain();
      reg_write(REG_POINT_COUNT, 2);
      add_cast(100, -400, 0, 16384);
      drain();

      // Six points: directions up, down, zero, diagonal, along the parallel segment.
      reg_write(REG_POINT_COUNT, 6);
      add_cast(300, 0, 0, 16384);
      add_cast(300, 0, 0, -16384);
      add_cast(300, 0, 0, 0);
      add_cast(-100, 200, 16384, 0);
      add_cast(32'sh80000000, 0, 16384, 0);
      add_cast(32'sh7FFFFFFF, 0, -16384, 0);
      add_cast(500, 0, 11585, 11585);
      add_cast(-200, -400, -16384, -16384);
      add_cast(32'sh80000000, 32'sh7FFFFFFF, 16384, -16384);
      drain();

      // Range extremes.
      reg_write(REG_MAX_RANGE, 1);
      add_cast(300, 0, 0, 16384);
      add_cast(300, 199, 0, 16384);
      drain();
      set_regs(6, 0, 26'h3FFFFFF);
      add_cast(300, 0, 0, 16384);
      drain();

      // Whole written track, widest radius; then an oversized count clamped
      // to the table.
      set_regs(TRACK_FILL, 4095, MAX_RANGE_RESET);
      add_cast(0, 0, 11585, -11585);
      drain();
      set_regs(8191, 2, MAX_RANGE_RESET);
      add_cast(0, 0, 0, 16384);
      add_cast(300, 0, -16384, 0);
      drain();

      // Random part: three idling profiles, long receiver stall in the last.
      while (random_items < 580) begin
         if (random_items < 195) begin
            send_idle_pct = 18;
            recv_idle_pct = 62;
         end else if (random_items < 390) begin
            send_idle_pct = 62;
            recv_idle_pct = 18;
         end else begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         random_phase(random_items >= 390 && hold_req == 0);
      end
      drain();

      $display("checked %0d cast results (%0d hits) over %0d random requests",
               casts_checked, hits_seen, random_items);
      if (errors == 0 && owed_results.size() == 0) begin
         $display("PASS polyline_ray_nearest_hit");
      end else begin
         $display("FAIL polyline_ray_nearest_hit");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
src/prnh_pkg.sv
src/prnh_ram.sv
src/prnh_front.sv
src/prnh_back.sv
src/polyline_ray_nearest_hit.sv
tb/tb_polyline_ray_nearest_hit.sv
